// ===== rtl/iss_pkg.sv =====
// shared types, codes and defaults of the indexed sequential search core
package iss_pkg;

  // default sizes
  localparam int LIST_DEPTH_DEF  = 1024;
  localparam int INDEX_DEPTH_DEF = 16;
  localparam int DATA_WIDTH_DEF  = 32;

  // fixed field widths
  localparam int SLOT_W  = 10;
  localparam int VALUE_W = 32;
  localparam int START_W = 10;
  localparam int POS_W   = 10;

  // configuration port
  localparam int CFG_INDEX_W = 1;
  localparam int CFG_DATA_W  = 11;
  localparam int LIST_COUNT_W  = 11;
  localparam int INDEX_COUNT_W = 5;
  localparam logic [CFG_INDEX_W-1:0] CFG_LIST_COUNT  = 1'd0;
  localparam logic [CFG_INDEX_W-1:0] CFG_INDEX_COUNT = 1'd1;

  // input mode codes
  localparam logic [1:0] MODE_LOAD_LIST  = 2'd0;
  localparam logic [1:0] MODE_LOAD_INDEX = 2'd1;
  localparam logic [1:0] MODE_SEARCH     = 2'd2;

  // depth of the queue between front and back
  localparam int QUEUE_DEPTH = 2;

  typedef struct packed {
    logic [1:0]                mode;
    logic [SLOT_W-1:0]         slot;
    logic signed [VALUE_W-1:0] value;
    logic [START_W-1:0]        start_position;
  } in_item_t;

  typedef struct packed {
    logic             found;
    logic [POS_W-1:0] position;
  } out_item_t;

  // operation classes handed from front to back
  typedef enum logic [1:0] {
    OP_LIST_WR,
    OP_INDEX_WR,
    OP_SEARCH
  } op_kind_t;

  typedef struct packed {
    op_kind_t                  kind;
    logic [SLOT_W-1:0]         slot;
    logic signed [VALUE_W-1:0] value;
    logic [START_W-1:0]        start;
  } op_t;

endpackage

// ===== rtl/indexed_sequential_search_core.sv =====
// top level of the indexed sequential search core
// Usage:
//   in_valid/in_stall/in_data carry load and search beats. A beat is taken at
//   a clock edge with in_valid high and in_stall low. Mode 0 writes a list
//   value, mode 1 writes an index key and block start, mode 2 searches.
//   out_valid/out_stall/out_data return one result beat per search only.
//   cfg_we/cfg_index/cfg_data write list_count (index 0) and index_count
//   (index 1); write them only while the core is idle.
// Timing:
//   The front decodes a beat in the cycle it arrives and queues it; a
//   two-entry queue feeds the back end, which runs one operation at a time.
//   A load is written to its memory as it leaves the queue. A search that
//   reaches its block walks the m index entries in use and then the block of
//   length L, one memory read per cycle; a hit or an early miss cuts the walk short.
// Reset and stall:
//   rst (synchronous) empties the queue and output and sets both counts to 1;
//   memory contents are undefined until written. While out_stall is high the
//   result holds, a finished search waits to hand over its result, and input
//   beats are taken until the queue fills.
module indexed_sequential_search_core #(
  parameter int LIST_DEPTH  = iss_pkg::LIST_DEPTH_DEF,
  parameter int INDEX_DEPTH = iss_pkg::INDEX_DEPTH_DEF,
  parameter int DATA_WIDTH  = iss_pkg::DATA_WIDTH_DEF
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             in_valid,
  output logic                             in_stall,
  input  iss_pkg::in_item_t                in_data,
  output logic                             out_valid,
  input  logic                             out_stall,
  output iss_pkg::out_item_t               out_data,
  input  logic                             cfg_we,
  input  logic [iss_pkg::CFG_INDEX_W-1:0]  cfg_index,
  input  logic [iss_pkg::CFG_DATA_W-1:0]   cfg_data
);
  import iss_pkg::*;

  logic [LIST_COUNT_W-1:0]  list_count;
  logic [INDEX_COUNT_W-1:0] index_count;
  logic                     push;
  op_t                      push_op;
  op_t                      head;
  logic                     q_full;
  logic                     q_empty;
  logic                     pop;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      list_count  <= LIST_COUNT_W'(1);
      index_count <= INDEX_COUNT_W'(1);
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_LIST_COUNT:  list_count  <= cfg_data[LIST_COUNT_W-1:0];
        CFG_INDEX_COUNT: index_count <= cfg_data[INDEX_COUNT_W-1:0];
        default:         list_count  <= list_count;
      endcase
    end
  end

  assign in_stall = q_full;

  iss_front #(
    .LIST_DEPTH  (LIST_DEPTH),
    .INDEX_DEPTH (INDEX_DEPTH)
  ) u_front (
    .in_valid (in_valid),
    .in_data  (in_data),
    .q_full   (q_full),
    .push     (push),
    .op       (push_op)
  );

  iss_queue u_queue (
    .clk     (clk),
    .rst     (rst),
    .push    (push),
    .push_op (push_op),
    .pop     (pop),
    .head    (head),
    .full    (q_full),
    .empty   (q_empty)
  );

  iss_back #(
    .LIST_DEPTH  (LIST_DEPTH),
    .INDEX_DEPTH (INDEX_DEPTH),
    .DATA_WIDTH  (DATA_WIDTH)
  ) u_back (
    .clk         (clk),
    .rst         (rst),
    .list_count  (list_count),
    .index_count (index_count),
    .head        (head),
    .q_empty     (q_empty),
    .pop         (pop),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .out_data    (out_data)
  );

endmodule

// ===== rtl/iss_ram.sv =====
// generic single-write, single-read ram with registered read data
module iss_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port and registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== rtl/iss_front.sv =====
// front end: decodes input beats into queued operations, drops no-ops
module iss_front #(
  parameter int LIST_DEPTH  = iss_pkg::LIST_DEPTH_DEF,
  parameter int INDEX_DEPTH = iss_pkg::INDEX_DEPTH_DEF
) (
  input  logic             in_valid,
  input  iss_pkg::in_item_t in_data,
  input  logic             q_full,
  output logic             push,
  output iss_pkg::op_t     op
);
  import iss_pkg::*;

  logic        keep;
  logic [31:0] slot_ext;

  assign slot_ext = 32'(in_data.slot);

  // classify the beat; out-of-range loads and the unused mode do nothing
  always_comb begin
    keep     = 1'b0;
    op.kind  = OP_SEARCH;
    op.slot  = in_data.slot;
    op.value = in_data.value;
    op.start = in_data.start_position;
    unique case (in_data.mode)
      MODE_LOAD_LIST: begin
        op.kind = OP_LIST_WR;
        keep    = (slot_ext < 32'(LIST_DEPTH));
      end
      MODE_LOAD_INDEX: begin
        op.kind = OP_INDEX_WR;
        keep    = (slot_ext < 32'(INDEX_DEPTH));
      end
      MODE_SEARCH: begin
        op.kind = OP_SEARCH;
        keep    = 1'b1;
      end
      default: begin
        keep = 1'b0;
      end
    endcase
  end

  assign push = in_valid && !q_full && keep;

endmodule

// ===== rtl/iss_queue.sv =====
// short operation queue between front and back
module iss_queue (
  input  logic         clk,
  input  logic         rst,
  input  logic         push,
  input  iss_pkg::op_t push_op,
  input  logic         pop,
  output iss_pkg::op_t head,
  output logic         full,
  output logic         empty
);
  import iss_pkg::*;

  localparam int QAW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int QCW = $clog2(QUEUE_DEPTH + 1);

  op_t            entries [QUEUE_DEPTH];
  logic [QAW-1:0] wr_ptr;
  logic [QAW-1:0] rd_ptr;
  logic [QCW-1:0] count;
  logic           do_push;
  logic           do_pop;

  assign full    = (count == QCW'(QUEUE_DEPTH));
  assign empty   = (count == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign head    = entries[rd_ptr];

  // storage
  always_ff @(posedge clk) begin
    if (do_push) begin
      entries[wr_ptr] <= push_op;
    end
  end

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == QAW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == QAW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

// ===== rtl/iss_back.sv =====
// back end: owns list and index memories, runs loads and searches in order
module iss_back #(
  parameter int LIST_DEPTH  = iss_pkg::LIST_DEPTH_DEF,
  parameter int INDEX_DEPTH = iss_pkg::INDEX_DEPTH_DEF,
  parameter int DATA_WIDTH  = iss_pkg::DATA_WIDTH_DEF
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic [iss_pkg::LIST_COUNT_W-1:0]     list_count,
  input  logic [iss_pkg::INDEX_COUNT_W-1:0]    index_count,
  input  iss_pkg::op_t                         head,
  input  logic                                 q_empty,
  output logic                                 pop,
  output logic                                 out_valid,
  input  logic                                 out_stall,
  output iss_pkg::out_item_t                   out_data
);
  import iss_pkg::*;

  localparam int LAW = (LIST_DEPTH > 1) ? $clog2(LIST_DEPTH) : 1;
  localparam int IAW = (INDEX_DEPTH > 1) ? $clog2(INDEX_DEPTH) : 1;
  localparam int IDW = $clog2(INDEX_DEPTH + 1);
  localparam int PW  = ((LAW > START_W) ? LAW : START_W) + 1;
  localparam int IW  = DATA_WIDTH + START_W;

  typedef enum logic [2:0] {
    S_IDLE,
    S_LO,
    S_HI,
    S_CHK,
    S_IX,
    S_BLK,
    S_SCAN,
    S_FIN
  } state_t;

  state_t state;

  // search registers
  logic [DATA_WIDTH-1:0] key;
  logic [IDW-1:0]        ix_cnt;
  logic                  ix_dv;
  logic                  have;
  logic                  just_sel;
  logic                  hi_valid;
  logic [PW-1:0]         lo;
  logic [PW-1:0]         hi;
  logic [PW-1:0]         ptr;
  logic [PW-1:0]         ptr_d;
  logic                  scan_dv;
  logic                  found;
  logic [POS_W-1:0]      position;

  // memory ports
  logic                  list_we;
  logic [LAW-1:0]        list_waddr;
  logic [LAW-1:0]        list_raddr;
  logic [DATA_WIDTH-1:0] list_rdata;
  logic                  index_we;
  logic [IAW-1:0]        index_waddr;
  logic [IAW-1:0]        index_raddr;
  logic [IW-1:0]         index_rdata;

  // derived values
  logic signed [63:0]    value_ext;
  logic [DATA_WIDTH-1:0] head_key;
  logic [31:0]           slot_ext;
  logic [31:0]           n_full;
  logic [31:0]           n_last_full;
  logic [31:0]           m_full;
  logic [LAW-1:0]        n_last;
  logic [PW-1:0]         n_last_w;
  logic [IDW-1:0]        m;
  logic [DATA_WIDTH-1:0] ix_key;
  logic [PW-1:0]         ix_start;
  logic                  ix_le;
  logic [PW-1:0]         hi_pick;
  logic [PW-1:0]         hi_eff;
  logic                  scan_go;
  logic                  fin_take;

  // stored width of a value: truncate or sign-extend
  assign value_ext = 64'(head.value);
  assign head_key  = value_ext[DATA_WIDTH-1:0];
  assign slot_ext  = 32'(head.slot);

  // clamp counts into their legal range
  assign n_full = (list_count == '0) ? 32'd1 :
                  (32'(list_count) > 32'(LIST_DEPTH)) ? 32'(LIST_DEPTH) : 32'(list_count);
  assign m_full = (index_count == '0) ? 32'd1 :
                  (32'(index_count) > 32'(INDEX_DEPTH)) ? 32'(INDEX_DEPTH) :
                  32'(index_count);
  assign n_last_full = n_full - 32'd1;
  assign n_last      = n_last_full[LAW-1:0];
  assign n_last_w    = n_last_full[PW-1:0];
  assign m           = m_full[IDW-1:0];

  // index entry under test
  assign ix_key   = index_rdata[IW-1:START_W];
  assign ix_start = PW'(index_rdata[START_W-1:0]);
  assign ix_le    = ($signed(ix_key) <= $signed(key));

  // block end: next entry's start or the last list element, capped
  assign hi_pick = hi_valid ? hi : n_last_w;
  assign hi_eff  = (hi_pick > n_last_w) ? n_last_w : hi_pick;
  assign scan_go = (ptr <= hi);

  // result moves into the output register
  assign fin_take = (state == S_FIN) && (!out_valid || !out_stall);

  // pop and memory control
  always_comb begin
    pop         = (state == S_IDLE) && !q_empty;
    list_we     = pop && (head.kind == OP_LIST_WR);
    index_we    = pop && (head.kind == OP_INDEX_WR);
    list_waddr  = slot_ext[LAW-1:0];
    index_waddr = slot_ext[IAW-1:0];
    index_raddr = ix_cnt[IAW-1:0];
    case (state)
      S_LO:    list_raddr = '0;
      S_HI:    list_raddr = n_last;
      default: list_raddr = ptr[LAW-1:0];
    endcase
  end

  iss_ram #(
    .WIDTH (DATA_WIDTH),
    .DEPTH (LIST_DEPTH)
  ) u_list_ram (
    .clk   (clk),
    .we    (list_we),
    .waddr (list_waddr),
    .wdata (head_key),
    .raddr (list_raddr),
    .rdata (list_rdata)
  );

  iss_ram #(
    .WIDTH (IW),
    .DEPTH (INDEX_DEPTH)
  ) u_index_ram (
    .clk   (clk),
    .we    (index_we),
    .waddr (index_waddr),
    .wdata ({head_key, head.start}),
    .raddr (index_raddr),
    .rdata (index_rdata)
  );

  // search sequencer and output register
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
      ix_dv     <= 1'b0;
      scan_dv   <= 1'b0;
    end else begin
      if (fin_take) begin
        out_valid <= 1'b1;
      end else if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (pop && head.kind == OP_SEARCH) begin
            key   <= head_key;
            state <= S_LO;
          end
        end
        // first element read issued
        S_LO: begin
          state <= S_HI;
        end
        // below the first element misses
        S_HI: begin
          found    <= 1'b0;
          position <= '0;
          if ($signed(key) < $signed(list_rdata)) begin
            state <= S_FIN;
          end else begin
            state <= S_CHK;
          end
        end
        // above the last element misses
        S_CHK: begin
          ix_cnt   <= '0;
          ix_dv    <= 1'b0;
          have     <= 1'b0;
          just_sel <= 1'b0;
          hi_valid <= 1'b0;
          if ($signed(key) > $signed(list_rdata)) begin
            state <= S_FIN;
          end else begin
            state <= S_IX;
          end
        end
        // walk the index: last entry with key at most the search key
        S_IX: begin
          if (ix_cnt < m) begin
            ix_cnt <= ix_cnt + 1'b1;
            ix_dv  <= 1'b1;
          end else begin
            ix_dv <= 1'b0;
          end
          if (ix_dv) begin
            just_sel <= ix_le;
            if (ix_le) begin
              have     <= 1'b1;
              lo       <= ix_start;
              hi_valid <= 1'b0;
            end else if (just_sel) begin
              hi       <= ix_start;
              hi_valid <= 1'b1;
            end
          end
          if (ix_cnt == m && !ix_dv) begin
            state <= S_BLK;
          end
        end
        // settle block bounds
        S_BLK: begin
          ptr     <= lo;
          hi      <= hi_eff;
          scan_dv <= 1'b0;
          if (!have || lo > hi_eff) begin
            state <= S_FIN;
          end else begin
            state <= S_SCAN;
          end
        end
        // scan the block one element per beat
        S_SCAN: begin
          if (scan_go) begin
            ptr     <= ptr + 1'b1;
            ptr_d   <= ptr;
            scan_dv <= 1'b1;
          end else begin
            scan_dv <= 1'b0;
          end
          if (scan_dv && list_rdata == key) begin
            found    <= 1'b1;
            position <= ptr_d[POS_W-1:0];
            scan_dv  <= 1'b0;
            state    <= S_FIN;
          end else if (!scan_go && !scan_dv) begin
            state <= S_FIN;
          end
        end
        // hand the result to the output register
        S_FIN: begin
          if (fin_take) begin
            out_data.found    <= found;
            out_data.position <= position;
            state             <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

// ===== test/tb_indexed_sequential_search_core.sv =====
// testbench for the indexed sequential search core: loads, searches and count settings
module tb_indexed_sequential_search_core;
  timeunit 1ns;
  timeprecision 1ps;

  import iss_pkg::*;

  // unused mode code, ignored by the core
  localparam logic [1:0] MODE_UNUSED = 2'd3;

  localparam logic signed [VALUE_W-1:0] VAL_MIN = 32'h8000_0000;
  localparam logic signed [VALUE_W-1:0] VAL_MAX = 32'h7FFF_FFFF;

  // idle cycles before a register write once all results are back
  localparam int DRAIN_CYCLES = 40;
  // length of the receiver's long hold-off
  localparam int HOLD_CYCLES = 400;

  typedef enum logic [1:0] {
    RX_FREE,
    RX_LIGHT,
    RX_HEAVY,
    RX_PERIODIC
  } rx_style_t;

  logic                   clk;
  logic                   rst       = 1'b1;
  logic                   in_valid  = 1'b0;
  logic                   in_stall;
  in_item_t               in_data   = '0;
  logic                   out_valid;
  logic                   out_stall = 1'b0;
  out_item_t              out_data;
  logic                   cfg_we    = 1'b0;
  logic [CFG_INDEX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0]  cfg_data  = '0;

  indexed_sequential_search_core DUT (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  // mirror of the core's contents and count registers
  logic signed [VALUE_W-1:0] list_mem        [LIST_DEPTH_DEF];
  logic signed [VALUE_W-1:0] index_key_mem   [INDEX_DEPTH_DEF];
  logic [START_W-1:0]        index_start_mem [INDEX_DEPTH_DEF];
  logic [LIST_COUNT_W-1:0]   list_cnt  = LIST_COUNT_W'(1);
  logic [INDEX_COUNT_W-1:0]  index_cnt = INDEX_COUNT_W'(1);

  out_item_t pending_results [$];
  int        fail_count   = 0;
  int        useful_beats = 0;

  // sender burst control
  bit sender_idles = 1'b1;
  int burst_left   = 0;

  // receiver stall pattern and hold-off
  int        holds_asked  = 0;
  int        holds_served = 0;
  int        hold_left    = 0;
  int        style_left   = 0;
  int        rx_tick      = 0;
  rx_style_t rx_style     = RX_FREE;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // run limit
  initial begin
    #50_000_000;
    $display("*** FAILED ***");
    $finish;
  end

  function automatic int eff_count(input int raw, input int depth);
    if (raw == 0) return 1;
    return (raw > depth) ? depth : raw;
  endfunction

  function automatic logic signed [VALUE_W-1:0] clamp32(input longint v);
    if (v > longint'(VAL_MAX)) return VAL_MAX;
    if (v < longint'(VAL_MIN)) return VAL_MIN;
    return v[VALUE_W-1:0];
  endfunction

  // expected outcome of a search against the mirrored contents
  function automatic out_item_t search_outcome(input logic signed [VALUE_W-1:0] key);
    out_item_t res;
    int n, m, sel, lo, hi;
    bit have;
    res  = '0;
    n    = eff_count(int'(list_cnt), LIST_DEPTH_DEF);
    m    = eff_count(int'(index_cnt), INDEX_DEPTH_DEF);
    sel  = 0;
    have = 1'b0;
    if (key < list_mem[0] || key > list_mem[n-1]) return res;
    for (int k = 0; k < m; k++) begin
      if (index_key_mem[k] <= key) begin
        sel  = k;
        have = 1'b1;
      end
    end
    if (!have) return res;
    lo = int'(index_start_mem[sel]);
    hi = (sel + 1 < m) ? int'(index_start_mem[sel+1]) : n - 1;
    if (hi > n - 1) hi = n - 1;
    if (lo > hi) return res;
    for (int p = lo; p <= hi; p++) begin
      if (list_mem[p] == key) begin
        res.found    = 1'b1;
        res.position = p[POS_W-1:0];
        return res;
      end
    end
    return res;
  endfunction

  function automatic in_item_t make_beat(input logic [1:0] mode, input logic [SLOT_W-1:0] slot,
                                         input logic signed [VALUE_W-1:0] value,
                                         input logic [START_W-1:0] start);
    in_item_t b;
    b.mode           = mode;
    b.slot           = slot;
    b.value          = value;
    b.start_position = start;
    return b;
  endfunction

  // update the mirror with an accepted beat
  task automatic absorb_beat(input in_item_t b);
    case (b.mode)
      MODE_LOAD_LIST: begin
        list_mem[b.slot] = b.value;
        useful_beats++;
      end
      MODE_LOAD_INDEX: begin
        if (b.slot < INDEX_DEPTH_DEF) begin
          index_key_mem[b.slot]   = b.value;
          index_start_mem[b.slot] = b.start_position;
          useful_beats++;
        end
      end
      MODE_SEARCH: begin
        pending_results.push_back(search_outcome(b.value));
        useful_beats++;
      end
      default: ;
    endcase
  endtask

  // offer one beat, wait for acceptance, then maybe pause between bursts
  task automatic send_beat(input in_item_t beat);
    in_valid <= 1'b1;
    in_data  <= beat;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    absorb_beat(beat);
    if (sender_idles) begin
      if (burst_left == 0) begin
        burst_left = $urandom_range(1, 20);
        in_valid <= 1'b0;
        repeat ($urandom_range(1, 6)) @(posedge clk);
      end else begin
        burst_left--;
      end
    end
  endtask

  task automatic search_for(input logic signed [VALUE_W-1:0] key);
    send_beat(make_beat(MODE_SEARCH, SLOT_W'($urandom_range(0, 1023)), key,
                        START_W'($urandom_range(0, 1023))));
  endtask

  // stop offering beats and let the core drain
  task automatic wait_idle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_config(input logic [CFG_INDEX_W-1:0] idx, input int unsigned data);
    wait_idle();
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data[CFG_DATA_W-1:0];
    @(posedge clk);
    cfg_we <= 1'b0;
    if (idx == CFG_LIST_COUNT) list_cnt = data[LIST_COUNT_W-1:0];
    else index_cnt = data[INDEX_COUNT_W-1:0];
  endtask

  // sorted list with random steps and duplicates
  task automatic fill_list(input int n);
    longint cur;
    case ($urandom_range(0, 3))
      0: cur = longint'(VAL_MIN);
      1: cur = longint'($signed($urandom));
      2: cur = longint'($urandom_range(0, 40)) - 20;
      default: cur = longint'(VAL_MAX) - 2 * n;
    endcase
    for (int p = 0; p < n; p++) begin
      send_beat(make_beat(MODE_LOAD_LIST, p[SLOT_W-1:0], clamp32(cur),
                          START_W'($urandom_range(0, 1023))));
      if ($urandom_range(0, 15) == 0) cur += longint'($urandom_range(0, 1 << 20));
      else cur += longint'($urandom_range(0, 3));
    end
  endtask

  // index entries spread over the list, now and then scrambled
  task automatic fill_index(input int n, input int m);
    bit broken;
    int s;
    logic signed [VALUE_W-1:0] key;
    broken = ($urandom_range(0, 5) == 0);
    for (int k = 0; k < m; k++) begin
      s   = broken ? $urandom_range(0, 1023) : (k * n) / m;
      key = list_mem[(s < n) ? s : n - 1];
      if (k == 0 && $urandom_range(0, 3) == 0) key = clamp32(longint'(key) + 1);
      send_beat(make_beat(MODE_LOAD_INDEX, k[SLOT_W-1:0], key, s[START_W-1:0]));
    end
  endtask

  // full-length list with only its two ends written; every block stays inside them
  task automatic fill_list_ends();
    int p;
    for (int j = 0; j < 16; j++) begin
      p = (j < 8) ? j : LIST_DEPTH_DEF - 16 + j;
      send_beat(make_beat(MODE_LOAD_LIST, p[SLOT_W-1:0], p * 3 - 100, '0));
    end
    send_beat(make_beat(MODE_LOAD_INDEX, '0, list_mem[0], '0));
    for (int k = 1; k < INDEX_DEPTH_DEF; k++) begin
      p = (k == INDEX_DEPTH_DEF - 1) ? LIST_DEPTH_DEF - 8 : 7;
      send_beat(make_beat(MODE_LOAD_INDEX, k[SLOT_W-1:0], list_mem[LIST_DEPTH_DEF-8],
                          p[START_W-1:0]));
    end
  endtask

  // search near a written entry at either end of the list
  task automatic search_ends();
    int p;
    p = $urandom_range(0, 15);
    p = (p < 8) ? p : LIST_DEPTH_DEF - 16 + p;
    case ($urandom_range(0, 3))
      0: search_for(list_mem[p] + 1);
      1: search_for(list_mem[p] - 1);
      default: search_for(list_mem[p]);
    endcase
  endtask

  task automatic start_phase(input int unsigned list_cfg, input int unsigned index_cfg,
                             input bit do_fill);
    write_config(CFG_LIST_COUNT, list_cfg);
    write_config(CFG_INDEX_COUNT, index_cfg);
    if (do_fill) begin
      fill_list(eff_count(int'(list_cnt), LIST_DEPTH_DEF));
      fill_index(eff_count(int'(list_cnt), LIST_DEPTH_DEF),
                 eff_count(int'(index_cnt), INDEX_DEPTH_DEF));
    end
  endtask

  // mostly searches for stored keys, plus near misses, stray loads and unused modes
  task automatic random_beat();
    int n, roll, p;
    logic signed [VALUE_W-1:0] key;
    n    = eff_count(int'(list_cnt), LIST_DEPTH_DEF);
    roll = $urandom_range(0, 99);
    p    = $urandom_range(0, n - 1);
    if (roll < 60) begin
      search_for(list_mem[p]);
    end else if (roll < 75) begin
      case ($urandom_range(0, 2))
        0: key = clamp32(longint'(list_mem[p]) + 1);
        1: key = clamp32(longint'(list_mem[p]) - 1);
        default: key = $urandom;
      endcase
      search_for(key);
    end else if (roll < 84) begin
      send_beat(make_beat(MODE_LOAD_LIST, SLOT_W'($urandom_range(0, 1023)), $urandom,
                          START_W'($urandom_range(0, 1023))));
    end else if (roll < 93) begin
      key = $urandom_range(0, 1) ? list_mem[p] : $urandom;
      send_beat(make_beat(MODE_LOAD_INDEX, SLOT_W'($urandom_range(0, 31)), key,
                          START_W'($urandom_range(0, 1023))));
    end else begin
      send_beat(make_beat(MODE_UNUSED, SLOT_W'($urandom_range(0, 1023)), $urandom,
                          START_W'($urandom_range(0, 1023))));
    end
  endtask

  // one-entry list and index at the reset counts
  task automatic test_reset_defaults();
    send_beat(make_beat(MODE_LOAD_LIST, '0, 5, '0));
    send_beat(make_beat(MODE_LOAD_INDEX, '0, 5, '0));
    search_for(5);
    search_for(4);
    search_for(6);
    send_beat(make_beat(MODE_UNUSED, 10'h3FF, VAL_MIN, 10'h3FF));
  endtask

  // zero counts behave as one
  task automatic test_count_floor();
    write_config(CFG_LIST_COUNT, 0);
    write_config(CFG_INDEX_COUNT, 0);
    search_for(5);
    send_beat(make_beat(MODE_LOAD_LIST, SLOT_W'(1), 9, '0));
    search_for(9);
  endtask

  // block selection, key below the first index key, extremes, empty block
  task automatic test_block_walk();
    logic signed [VALUE_W-1:0] vals [8];
    vals = '{VAL_MIN, VAL_MIN, -5, 0, 0, 7, VAL_MAX - 1, VAL_MAX};
    write_config(CFG_LIST_COUNT, 8);
    write_config(CFG_INDEX_COUNT, 3);
    for (int p = 0; p < 8; p++) send_beat(make_beat(MODE_LOAD_LIST, p[SLOT_W-1:0], vals[p], '0));
    send_beat(make_beat(MODE_LOAD_INDEX, '0, -4, '0));
    send_beat(make_beat(MODE_LOAD_INDEX, SLOT_W'(1), 0, START_W'(3)));
    send_beat(make_beat(MODE_LOAD_INDEX, SLOT_W'(2), VAL_MAX - 1, START_W'(6)));
    search_for(VAL_MIN);
    send_beat(make_beat(MODE_LOAD_INDEX, '0, VAL_MIN, '0));
    search_for(VAL_MIN);
    search_for(-5);
    search_for(0);
    search_for(1);
    search_for(7);
    search_for(VAL_MAX);
    // slots past the index table are dropped
    send_beat(make_beat(MODE_LOAD_INDEX, SLOT_W'(16), VAL_MIN, '0));
    send_beat(make_beat(MODE_LOAD_INDEX, 10'h3FF, VAL_MAX, 10'h3FF));
    // last block starting past the list end
    send_beat(make_beat(MODE_LOAD_INDEX, SLOT_W'(2), VAL_MAX - 1, START_W'(9)));
    search_for(VAL_MAX);
  endtask

  // full list and index, reached by saturation and by exact counts
  task automatic test_full_depth();
    start_phase(2047, 31, 1'b0);
    fill_list_ends();
    repeat (30) search_ends();
    search_for(list_mem[LIST_DEPTH_DEF-1]);
    start_phase(LIST_DEPTH_DEF, INDEX_DEPTH_DEF, 1'b0);
    repeat (20) search_ends();
    search_for(list_mem[LIST_DEPTH_DEF-1]);
  endtask

  task automatic test_random_phases();
    int base, lcfg, icfg;
    base = useful_beats;
    while (useful_beats - base < 500) begin
      sender_idles = ($urandom_range(0, 3) != 0);
      case ($urandom_range(0, 9))
        0: lcfg = 1;
        1: lcfg = 0;
        default: lcfg = $urandom_range(2, 48);
      endcase
      icfg = $urandom_range(0, 1) ? $urandom_range(1, 16) : $urandom_range(0, 31);
      start_phase(lcfg, icfg, 1'b1);
      repeat ($urandom_range(30, 60)) random_beat();
    end
    sender_idles = 1'b1;
  endtask

  // receiver holds off while searches keep coming
  task automatic test_backpressure();
    start_phase(32, 4, 1'b1);
    sender_idles = 1'b0;
    holds_asked <= holds_asked + 1;
    repeat (24) search_for(list_mem[$urandom_range(0, 31)]);
    sender_idles = 1'b1;
  endtask

  // receiver stall pattern
  always @(posedge clk) begin
    if (rst) begin
      out_stall  <= 1'b0;
      hold_left  <= 0;
      style_left <= 0;
    end else if (hold_left != 0) begin
      out_stall <= 1'b1;
      hold_left <= hold_left - 1;
    end else if (holds_served != holds_asked) begin
      holds_served <= holds_asked;
      hold_left    <= HOLD_CYCLES;
      out_stall    <= 1'b1;
    end else begin
      rx_tick <= rx_tick + 1;
      if (style_left == 0) begin
        rx_style   <= rx_style_t'($urandom_range(0, 3));
        style_left <= $urandom_range(32, 256);
      end else begin
        style_left <= style_left - 1;
      end
      case (rx_style)
        RX_FREE:  out_stall <= 1'b0;
        RX_LIGHT: out_stall <= ($urandom_range(0, 3) == 0);
        RX_HEAVY: out_stall <= ($urandom_range(0, 3) != 0);
        default:  out_stall <= (rx_tick % 4 != 0);
      endcase
    end
  end

  // compare each result beat with the oldest expectation
  always @(posedge clk) begin : result_check
    out_item_t want;
    if (!rst && out_valid && !out_stall) begin
      if (pending_results.size() == 0) begin
        $error("result beat with nothing expected: found=%0d position=%0d",
               out_data.found, out_data.position);
        fail_count++;
      end else begin
        want = pending_results.pop_front();
        if (out_data.found !== want.found) begin
          $error("found: expected %0d, actual %0d", want.found, out_data.found);
          fail_count++;
        end
        if (out_data.position !== want.position) begin
          $error("position: expected %0d, actual %0d", want.position, out_data.position);
          fail_count++;
        end
      end
    end
  end

  initial begin
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    test_reset_defaults();
    test_count_floor();
    test_block_walk();
    test_full_depth();
    test_random_phases();
    test_backpressure();
    wait_idle();
    if (fail_count == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
